// ----- hdl/prq_pkg.sv -----
`timescale 1ns / 1ps
// prq_pkg: opcodes, status codes and fixed field widths of the priority ready queue
// no dependencies; used by the channel interfaces and the queue module

package prq_pkg;

  // fixed widths of the channel fields
  localparam int OP_W       = 2;
  localparam int PID_W      = 8;
  localparam int PRI_REQ_W  = 2;
  localparam int STATUS_W   = 2;

  // request opcodes
  localparam logic [OP_W-1:0] OP_PUSH = 2'd0;
  localparam logic [OP_W-1:0] OP_POP  = 2'd1;
  localparam logic [OP_W-1:0] OP_SET  = 2'd2;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

// ----- hdl/prq_in_if.sv -----
`timescale 1ns / 1ps
// prq_in_if: request channel of the priority ready queue (valid/ready plus request fields)
// depends on prq_pkg for the field widths

interface prq_in_if;
  logic                           valid;
  logic                           ready;
  logic [prq_pkg::OP_W-1:0]       op;
  logic [prq_pkg::PID_W-1:0]      pid;
  logic [prq_pkg::PRI_REQ_W-1:0]  priority_req;

  modport source (output valid, output op, output pid, output priority_req, input ready);
  modport sink   (input valid, input op, input pid, input priority_req, output ready);
endinterface

// ----- hdl/prq_out_if.sv -----
`timescale 1ns / 1ps
// prq_out_if: result channel of the priority ready queue (valid/ready plus result fields)
// depends on prq_pkg for the field widths

interface prq_out_if;
  logic                          valid;
  logic                          ready;
  logic                          pid_valid;
  logic [prq_pkg::PID_W-1:0]     popped_pid;
  logic [prq_pkg::STATUS_W-1:0]  status;

  modport source (output valid, output pid_valid, output popped_pid, output status,
                  input ready);
  modport sink   (input valid, input pid_valid, input popped_pid, input status,
                  output ready);
endinterface

// ----- hdl/prq_ram.sv -----
`timescale 1ns / 1ps
// prq_ram: generic simple dual-port RAM, one write port, one registered read port
// no dependencies

module prq_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hdl/priority_ready_queue.sv -----
`timescale 1ns / 1ps
// priority_ready_queue: bounded ready queue of pids, FIFO order within each priority level
// depends on prq_pkg, prq_in_if, prq_out_if and prq_ram
//
// Usage:
//   in_ch carries one request per transfer: op (push, pop, set priority), pid and
//   priority_req. out_ch returns exactly one result per request, in request order:
//   pid_valid, popped_pid and status (ok, full on a dropped push, empty on a pop of an empty queue).
//   Entries sit packed in arrival order in one RAM (pid and priority per word),
//   oldest at address 0; occupancy is a register.
//   Work, from request transfer to result valid:
//     push / unused opcode / pop or set on an empty queue: straight to the finish state
//     set priority: one RAM read per entry, matching entries rewritten in flight
//     pop: a scan for the oldest best entry, then a shift of the younger entries
//     down by one
//   The RAM has a registered read and a single read port.
//   One request is worked on at a time; in_ch.ready is high while idle, also when
//   a finished result still waits in the output register.
//   Reset (rst_n low, synchronous) empties the queue and drops any pending result;
//   RAM contents are not cleared. If out_ch stalls, the finished request waits
//   until the output register frees up before the next request is taken.

module priority_ready_queue #(
  parameter int DEPTH    = 16,
  parameter int PID_BITS = 8,
  parameter int LEVELS   = 4
) (
  input  logic      clk,
  input  logic      rst_n,
  prq_in_if.sink    in_ch,
  prq_out_if.source out_ch
);

  localparam int AW     = $clog2(DEPTH);
  localparam int OCC_W  = $clog2(DEPTH + 1);
  localparam int PRI_W  = $clog2(LEVELS);
  localparam int WORD_W = PID_BITS + PRI_W;

  // controller states
  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_SHIFT  = 2'd2;
  localparam logic [1:0] S_FINISH = 2'd3;

  logic [1:0]                    state_r, state_nxt;
  logic [OCC_W-1:0]              occ_r, occ_nxt;
  logic [OCC_W-1:0]              idx_r, idx_nxt;
  logic [AW-1:0]                 tag_r, tag_nxt;
  logic                          ld_r, ld_nxt;
  logic [prq_pkg::OP_W-1:0]      op_r, op_nxt;
  logic [PID_BITS-1:0]           pid_r, pid_nxt;
  logic [PRI_W-1:0]              pri_r, pri_nxt;
  logic [prq_pkg::STATUS_W-1:0]  status_r, status_nxt;
  logic                          best_valid_r, best_valid_nxt;
  logic [PRI_W-1:0]              best_pri_r, best_pri_nxt;
  logic [AW-1:0]                 best_idx_r, best_idx_nxt;
  logic [PID_BITS-1:0]           best_pid_r, best_pid_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_pid_valid_r, out_pid_valid_nxt;
  logic [prq_pkg::PID_W-1:0]     out_pid_r, out_pid_nxt;
  logic [prq_pkg::STATUS_W-1:0]  out_status_r, out_status_nxt;

  logic                          in_xfer;
  logic [PID_BITS-1:0]           pid_m;
  logic [PRI_W-1:0]              pri_c;
  logic                          issue;
  logic                          better;
  logic                          scan_last;
  logic                          out_free;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr;
  logic [WORD_W-1:0]             ram_wdata;
  logic [WORD_W-1:0]             ram_rdata;
  logic [PID_BITS-1:0]           rd_pid;
  logic [PRI_W-1:0]              rd_pri;

  prq_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  // request decode: mask the pid, saturate the priority
  assign in_xfer = in_ch.valid && in_ch.ready;
  assign pid_m   = PID_BITS'(in_ch.pid);
  assign pri_c   = (32'(in_ch.priority_req) >= 32'(LEVELS)) ? PRI_W'(LEVELS - 1)
                                                             : PRI_W'(in_ch.priority_req);

  assign rd_pid  = ram_rdata[WORD_W-1:PRI_W];
  assign rd_pri  = ram_rdata[PRI_W-1:0];

  // read issue and scan bookkeeping
  assign issue     = ((state_r == S_SCAN) || (state_r == S_SHIFT)) && (idx_r < occ_r);
  assign better    = !best_valid_r || (rd_pri < best_pri_r);
  assign scan_last = ld_r && (OCC_W'(tag_r) == occ_r - OCC_W'(1));
  assign out_free  = !out_valid_r || out_ch.ready;

  // RAM write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = tag_r;
    ram_wdata = ram_rdata;
    unique case (state_r)
      S_IDLE: begin
        ram_waddr = occ_r[AW-1:0];
        ram_wdata = {pid_m, pri_c};
        ram_we    = in_xfer && (in_ch.op == prq_pkg::OP_PUSH) && (occ_r < OCC_W'(DEPTH));
      end
      S_SCAN: begin
        ram_wdata = {pid_r, pri_r};
        ram_we    = ld_r && (op_r == prq_pkg::OP_SET) && (rd_pid == pid_r);
      end
      S_SHIFT: begin
        ram_waddr = tag_r - AW'(1);
        ram_we    = ld_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // controller
  always_comb begin
    state_nxt      = state_r;
    occ_nxt        = occ_r;
    idx_nxt        = idx_r;
    tag_nxt        = idx_r[AW-1:0];
    ld_nxt         = issue;
    op_nxt         = op_r;
    pid_nxt        = pid_r;
    pri_nxt        = pri_r;
    status_nxt     = status_r;
    best_valid_nxt = best_valid_r;
    best_pri_nxt   = best_pri_r;
    best_idx_nxt   = best_idx_r;
    best_pid_nxt   = best_pid_r;
    if (issue) begin
      idx_nxt = idx_r + OCC_W'(1);
    end
    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          op_nxt         = in_ch.op;
          pid_nxt        = pid_m;
          pri_nxt        = pri_c;
          status_nxt     = prq_pkg::ST_OK;
          idx_nxt        = '0;
          best_valid_nxt = 1'b0;
          state_nxt      = S_FINISH;
          case (in_ch.op)
            prq_pkg::OP_PUSH: begin
              if (occ_r < OCC_W'(DEPTH)) begin
                occ_nxt = occ_r + OCC_W'(1);
              end else begin
                status_nxt = prq_pkg::ST_FULL;
              end
            end
            prq_pkg::OP_POP: begin
              if (occ_r == '0) begin
                status_nxt = prq_pkg::ST_EMPTY;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            prq_pkg::OP_SET: begin
              if (occ_r != '0) begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
              state_nxt = S_FINISH;
            end
          endcase
        end
      end
      S_SCAN: begin
        // track the oldest entry with the lowest priority
        if (ld_r && better) begin
          best_valid_nxt = 1'b1;
          best_pri_nxt   = rd_pri;
          best_idx_nxt   = tag_r;
          best_pid_nxt   = rd_pid;
        end
        if (scan_last) begin
          if (op_r == prq_pkg::OP_POP) begin
            state_nxt = S_SHIFT;
            idx_nxt   = OCC_W'(better ? tag_r : best_idx_r) + OCC_W'(1);
          end else begin
            state_nxt = S_FINISH;
          end
        end
      end
      S_SHIFT: begin
        // younger entries move down by one, then the tail is dropped
        if (!issue && !ld_r) begin
          occ_nxt   = occ_r - OCC_W'(1);
          state_nxt = S_FINISH;
        end
      end
      S_FINISH: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt     = out_valid_r && !out_ch.ready;
    out_pid_valid_nxt = out_pid_valid_r;
    out_pid_nxt       = out_pid_r;
    out_status_nxt    = out_status_r;
    if ((state_r == S_FINISH) && out_free) begin
      out_valid_nxt     = 1'b1;
      out_pid_valid_nxt = (op_r == prq_pkg::OP_POP) && (status_r == prq_pkg::ST_OK);
      out_pid_nxt       = out_pid_valid_nxt ? prq_pkg::PID_W'(best_pid_r) : '0;
      out_status_nxt    = status_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      occ_r       <= '0;
      ld_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      ld_r        <= ld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload and scan registers
  always_ff @(posedge clk) begin
    idx_r           <= idx_nxt;
    tag_r           <= tag_nxt;
    op_r            <= op_nxt;
    pid_r           <= pid_nxt;
    pri_r           <= pri_nxt;
    status_r        <= status_nxt;
    best_valid_r    <= best_valid_nxt;
    best_pri_r      <= best_pri_nxt;
    best_idx_r      <= best_idx_nxt;
    best_pid_r      <= best_pid_nxt;
    out_pid_valid_r <= out_pid_valid_nxt;
    out_pid_r       <= out_pid_nxt;
    out_status_r    <= out_status_nxt;
  end

  assign in_ch.ready       = (state_r == S_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.pid_valid  = out_pid_valid_r;
  assign out_ch.popped_pid = out_pid_r;
  assign out_ch.status     = out_status_r;

`ifndef SYNTHESIS
  // occupancy never exceeds the pool
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= OCC_W'(DEPTH))
    else $error("occupancy above depth");

  // occupancy moves by at most one entry per cycle
  a_occ_step: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r != $past(occ_r)) |->
      ((occ_r == $past(occ_r) + OCC_W'(1)) || (occ_r == $past(occ_r) - OCC_W'(1))))
    else $error("occupancy jumped");

  // a popped pid always comes with ok status
  a_pop_status: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_pid_valid_r) |-> (out_status_r == prq_pkg::ST_OK))
    else $error("popped pid with error status");

  // only a pop shifts entries, and only on a non-empty queue
  a_shift_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHIFT) |-> ((op_r == prq_pkg::OP_POP) && (occ_r != '0)))
    else $error("shift outside a pop");

  // a set or pop scan never reads past the held entries
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    (ld_r && (state_r == S_SCAN)) |-> (OCC_W'(tag_r) < occ_r))
    else $error("scan read beyond occupancy");
`endif

endmodule
